// ===== src/stb_pkg.sv =====
// Shared types and constants for the software timer bank.
package stb_pkg;

	// Slot count of the bank and the part of it that the 4-bit index reaches
	localparam int TIMERS = 16;
	localparam int SLOTS  = (TIMERS < 16) ? TIMERS : 16;
	localparam int IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW     = $clog2(SLOTS + 1);

	// Field widths
	localparam int TIME_W = 32;
	localparam int IDX_W  = 4;

	typedef enum logic [1:0] {
		MODE_TICK   = 2'd0,
		MODE_SET    = 2'd1,
		MODE_PAUSE  = 2'd2,
		MODE_CANCEL = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_ASSIGNED = 2'd0,
		KIND_EXPIRED  = 2'd1,
		KIND_FULL     = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} state_t;

	// One slot's stored record
	typedef struct packed {
		logic              rep;
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] remaining;
	} slot_rec_t;

	// Memory access request from the sequencer
	typedef struct packed {
		logic          rd_en;
		logic [IW-1:0] rd_addr;
		logic          wr_en;
		logic [IW-1:0] wr_addr;
		slot_rec_t     wr_data;
	} mem_req_t;

	// One result transaction
	typedef struct packed {
		kind_t            kind;
		logic [IDX_W-1:0] index;
		logic             last;
	} res_t;

	typedef struct packed {
		logic valid;
		res_t res;
	} push_t;

endpackage

// ===== src/stb_mem.sv =====
// Slot record memory: one write port, one registered read port.
module stb_mem
	import stb_pkg::*;
(
	input  logic      clk,
	input  mem_req_t  req,
	output slot_rec_t rd_data
);

	slot_rec_t mem [SLOTS];
	slot_rec_t rd_data_q;

	// Read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/stb_out.sv =====
// Output register for result transactions.
module stb_out
	import stb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  push_t            push,
	output logic             can_push,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       kind,
	output logic [IDX_W-1:0] index,
	output logic             last
);

	logic out_valid_q;
	res_t res_q;

	assign can_push = !out_valid_q || !out_stall;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (push.valid) begin
			res_q <= push.res;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = res_q.kind;
	assign index     = res_q.index;
	assign last      = res_q.last;

endmodule

// ===== src/stb_ctrl.sv =====
// Sequencer: decodes requests, walks slots on a tick, holds live and pause flags.
module stb_ctrl
	import stb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        mode,
	input  logic [TIME_W-1:0] delta,
	input  logic [TIME_W-1:0] duration,
	input  logic              repeat_req,
	input  logic [IDX_W-1:0]  slot,
	output mem_req_t          mem_req,
	input  slot_rec_t         rd_data,
	input  logic              can_push,
	output push_t             push
);

	state_t            state_q, state_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic              v_s1, v_d;
	logic [IW-1:0]     idx_s1, idx_d;
	logic [TIME_W-1:0] delta_q, delta_d;
	logic [SLOTS-1:0]  alive_q, alive_d;
	logic [SLOTS-1:0]  frozen_q, frozen_d;
	logic              pend_v_q, pend_v_d;
	res_t              pend_q, pend_d;

	logic              issuing, live, expire, advance;
	logic              found, in_range;
	logic [IW-1:0]     fidx, sl;
	slot_rec_t         new_rec;

	// Lowest free slot
	always_comb begin
		found = 1'b0;
		fidx  = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!alive_q[i]) begin
				found = 1'b1;
				fidx  = IW'(i);
			end
		end
	end

	assign sl       = slot[IW-1:0];
	assign in_range = (5'(slot) < 5'(SLOTS));

	// Walk stage decode
	assign issuing = (cnt_q < CW'(SLOTS));
	assign live    = alive_q[idx_s1] && !frozen_q[idx_s1];
	assign expire  = v_s1 && live && (delta_q > rd_data.remaining);
	assign advance = !(expire && pend_v_q && !can_push);

	// Next state and outputs
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		v_d      = v_s1;
		idx_d    = idx_s1;
		delta_d  = delta_q;
		alive_d  = alive_q;
		frozen_d = frozen_q;
		pend_v_d = pend_v_q;
		pend_d   = pend_q;
		mem_req  = '0;
		push     = '0;
		new_rec  = rd_data;
		in_stall = (state_q != ST_IDLE);

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (mode_t'(mode))
						MODE_TICK: begin
							delta_d = delta;
							cnt_d   = '0;
							v_d     = 1'b0;
							state_d = ST_WALK;
						end
						MODE_SET: begin
							if (found) begin
								mem_req.wr_en             = 1'b1;
								mem_req.wr_addr           = fidx;
								mem_req.wr_data.rep       = repeat_req;
								mem_req.wr_data.period    = duration;
								mem_req.wr_data.remaining = duration;
								alive_d[fidx]             = 1'b1;
								frozen_d[fidx]            = 1'b0;
								pend_d.kind               = KIND_ASSIGNED;
								pend_d.index              = IDX_W'(fidx);
							end else begin
								pend_d.kind  = KIND_FULL;
								pend_d.index = '0;
							end
							pend_d.last = 1'b1;
							pend_v_d    = 1'b1;
							state_d     = ST_FLUSH;
						end
						MODE_PAUSE: begin
							if (in_range) begin
								frozen_d[sl] = 1'b1;
							end
						end
						MODE_CANCEL: begin
							if (in_range) begin
								alive_d[sl] = 1'b0;
							end
						end
					endcase
				end
			end
			ST_WALK: begin
				if (advance) begin
					// update the slot whose record just arrived
					if (v_s1 && live) begin
						if (expire) begin
							if (rd_data.rep) begin
								new_rec.remaining = rd_data.period;
							end else begin
								alive_d[idx_s1] = 1'b0;
							end
						end else begin
							new_rec.remaining = rd_data.remaining - delta_q;
						end
						mem_req.wr_en   = 1'b1;
						mem_req.wr_addr = idx_s1;
						mem_req.wr_data = new_rec;
					end
					// an earlier expiry is not the last one
					if (expire) begin
						if (pend_v_q) begin
							push.valid    = 1'b1;
							push.res      = pend_q;
							push.res.last = 1'b0;
						end
						pend_d.kind  = KIND_EXPIRED;
						pend_d.index = IDX_W'(idx_s1);
						pend_d.last  = 1'b1;
						pend_v_d     = 1'b1;
					end
					// fetch the next slot
					mem_req.rd_en   = issuing;
					mem_req.rd_addr = cnt_q[IW-1:0];
					idx_d           = cnt_q[IW-1:0];
					v_d             = issuing;
					if (issuing) begin
						cnt_d = cnt_q + CW'(1);
					end else begin
						state_d = pend_v_d ? ST_FLUSH : ST_IDLE;
					end
				end
			end
			ST_FLUSH: begin
				if (can_push) begin
					push.valid    = 1'b1;
					push.res      = pend_q;
					push.res.last = 1'b1;
					pend_v_d      = 1'b0;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			v_s1     <= 1'b0;
			alive_q  <= '0;
			frozen_q <= '0;
			pend_v_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			v_s1     <= v_d;
			alive_q  <= alive_d;
			frozen_q <= frozen_d;
			pend_v_q <= pend_v_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		idx_s1  <= idx_d;
		delta_q <= delta_d;
		pend_q  <= pend_d;
	end

endmodule

// ===== src/software_timer_bank.sv =====
// Top level of the software timer bank.
//
// Input channel (in_valid/in_stall) carries one request per transaction:
// mode selects tick, set, pause or cancel; delta, duration, repeat_req and
// slot are its operands. Output channel (out_valid/out_stall) carries result
// transactions: kind, index, and last on the final result of a request.
// Pause and cancel produce no result.
// Set: the slot is claimed on accept, and the assigned or bank-full result is
// held in the pending register and then presented from the output register.
// Tick walks the slots in ascending order, one slot per cycle while the
// output register takes results, through the slot memory's registered read
// port, and then hands over its final expiry result, if any; each slot
// record goes through a read-modify-write.
// An expiry is held back until the next one is found so that last can be
// marked; when the receiver stalls, the walk halts on the next expiring slot
// and resumes once the output register frees up.
// Reset clears the live and pause flags and the control state; slot records
// are not reset, and a record is only acted on after a set has written it.
module software_timer_bank
	import stb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        mode,
	input  logic [TIME_W-1:0] delta,
	input  logic [TIME_W-1:0] duration,
	input  logic              repeat_req,
	input  logic [IDX_W-1:0]  slot,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        kind,
	output logic [IDX_W-1:0]  index,
	output logic              last
);

	mem_req_t  mem_req;
	slot_rec_t rd_data;
	push_t     push;
	logic      can_push;

	stb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.delta      (delta),
		.duration   (duration),
		.repeat_req (repeat_req),
		.slot       (slot),
		.mem_req    (mem_req),
		.rd_data    (rd_data),
		.can_push   (can_push),
		.push       (push)
	);

	stb_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	stb_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.can_push  (can_push),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.index     (index),
		.last      (last)
	);

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the software timer bank: directed cases, then random traffic.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import stb_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 3 * (SLOTS + 4);
	localparam int MAX_PRINTS = 40;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic              in_stall;
	logic [1:0]        mode       = MODE_TICK;
	logic [TIME_W-1:0] delta      = '0;
	logic [TIME_W-1:0] duration   = '0;
	logic              repeat_req = 1'b0;
	logic [IDX_W-1:0]  slot       = '0;
	logic              out_valid;
	logic              out_stall  = 1'b0;
	logic [1:0]        kind;
	logic [IDX_W-1:0]  index;
	logic              last;

	// Shadow copy of the timer bank
	logic [TIME_W-1:0] time_left [SLOTS];
	logic [TIME_W-1:0] time_len  [SLOTS];
	logic              live      [SLOTS];
	logic              paused    [SLOTS];
	logic              looping   [SLOTS];

	// Results predicted but not yet seen on the output channel
	res_t pending_results [$];

	int gap_pct     = 0;
	int stall_pct   = 0;
	int errors      = 0;
	int cycle_count = 0;

	software_timer_bank dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.delta      (delta),
		.duration   (duration),
		.repeat_req (repeat_req),
		.slot       (slot),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.index      (index),
		.last       (last)
	);

	always #10 clk = ~clk;

	// Run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("ERROR at cycle %0d: %s", cycle_count, what);
	endtask

	// Update the shadow bank for one accepted transaction and queue its results
	function automatic void timer_predict(input mode_t m, input logic [TIME_W-1:0] dt,
			input logic [TIME_W-1:0] dur, input logic rep, input logic [IDX_W-1:0] sl);
		int   s;
		int   i;
		int   hits [$];
		res_t r;
		case (m)
			MODE_TICK: begin
				for (s = 0; s < SLOTS; s++) begin
					if (live[s] && !paused[s]) begin
						if (dt > time_left[s]) begin
							// expiry: reload the full length, overshoot is dropped
							if (looping[s])
								time_left[s] = time_len[s];
							else
								live[s] = 1'b0;
							hits.push_back(s);
						end else begin
							time_left[s] = time_left[s] - dt;
						end
					end
				end
				for (i = 0; i < hits.size(); i++) begin
					r.kind  = KIND_EXPIRED;
					r.index = hits[i][IDX_W-1:0];
					r.last  = (i == hits.size() - 1);
					pending_results.push_back(r);
				end
			end
			MODE_SET: begin
				r.kind  = KIND_FULL;
				r.index = '0;
				r.last  = 1'b1;
				for (s = 0; s < SLOTS; s++) begin
					if (!live[s] && r.kind == KIND_FULL) begin
						time_left[s] = dur;
						time_len[s]  = dur;
						looping[s]   = rep;
						paused[s]    = 1'b0;
						live[s]      = 1'b1;
						r.kind       = KIND_ASSIGNED;
						r.index      = s[IDX_W-1:0];
					end
				end
				pending_results.push_back(r);
			end
			MODE_PAUSE: begin
				if (sl < SLOTS)
					paused[sl] = 1'b1;
			end
			default: begin
				if (sl < SLOTS)
					live[sl] = 1'b0;
			end
		endcase
	endfunction

	// Random live slot, or -1 when the bank is empty
	function automatic int pick_live_slot();
		int s;
		int found [$];
		for (s = 0; s < SLOTS; s++)
			if (live[s])
				found.push_back(s);
		if (found.size() == 0)
			return -1;
		return found[$urandom_range(found.size() - 1)];
	endfunction

	// Present one transaction at the falling edge and hold it until accepted
	task automatic send_item(input mode_t m, input logic [TIME_W-1:0] dt,
			input logic [TIME_W-1:0] dur, input logic rep, input logic [IDX_W-1:0] sl);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		mode       <= m;
		delta      <= dt;
		duration   <= dur;
		repeat_req <= rep;
		slot       <= sl;
		in_valid   <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		timer_predict(m, dt, dur, rep, sl);
		@(negedge clk);
	endtask

	// Receiver back-pressure
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// Result checker
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind=%0d index=%0d last=%0d",
					kind, index, last));
			end else begin
				want = pending_results.pop_front();
				if (kind !== want.kind || index !== want.index || last !== want.last)
					report_mismatch($sformatf(
						"result kind=%0d index=%0d last=%0d, want kind=%0d index=%0d last=%0d",
						kind, index, last, want.kind, want.index, want.last));
			end
		end
	end

	// Tick, cancel and pause on a bank with no live timers
	task automatic test_idle_bank();
		send_item(MODE_TICK, '0, '1, 1'b1, '1);
		send_item(MODE_CANCEL, '1, '0, 1'b0, 4'hF);
		// pause of a free slot, cleared later by the set that takes it
		send_item(MODE_PAUSE, '0, '0, 1'b1, 4'h0);
	endtask

	// Equal time, loop reload with overshoot, pause, one-shot expiry
	task automatic test_timer_cases();
		send_item(MODE_SET, '1, 32'd5, 1'b0, '0);
		send_item(MODE_SET, '0, 32'hFFFF_FFFF, 1'b0, '1);
		send_item(MODE_SET, '1, 32'd3, 1'b1, '0);
		// slot 0 hits exactly zero, slot 2 expires and reloads
		send_item(MODE_TICK, 32'd5, '1, 1'b0, '0);
		send_item(MODE_PAUSE, '0, '1, 1'b0, 4'd2);
		// largest delta: slots 0 and 1 expire, paused slot 2 holds
		send_item(MODE_TICK, 32'hFFFF_FFFF, '0, 1'b1, '1);
		send_item(MODE_CANCEL, '0, '0, 1'b0, 4'd2);
	endtask

	// Fill every slot, overflow, then expire all of them in one tick
	task automatic test_bank_full();
		int i;
		for (i = 0; i < SLOTS; i++)
			send_item(MODE_SET, $urandom, i, i[0], '0);
		send_item(MODE_SET, '0, 32'd7, 1'b1, '0);
		send_item(MODE_TICK, 32'hFFFF_FFFF, '0, 1'b0, '0);
	endtask

	// Random traffic, mostly well-formed timer use with some noise
	task automatic test_random(input int n_items, input int gap, input int stall);
		int                i;
		int                pick;
		int                sel;
		int                pick_slot;
		logic [TIME_W-1:0] dt;
		logic [TIME_W-1:0] dur;
		logic [IDX_W-1:0]  sl;
		gap_pct   = gap;
		stall_pct = stall;
		for (i = 0; i < n_items; i++) begin
			pick      = $urandom_range(99);
			sel       = $urandom_range(9);
			pick_slot = pick_live_slot();
			sl        = (pick_slot >= 0 && sel < 7) ? pick_slot[IDX_W-1:0]
				: IDX_W'($urandom_range(15));
			if (pick < 5) begin
				send_item(mode_t'($urandom_range(3)), $urandom, $urandom,
					1'($urandom_range(1)), IDX_W'($urandom_range(15)));
			end else if (pick < 40) begin
				if (pick_slot >= 0 && sel < 2)
					dt = time_left[pick_slot];
				else if (sel == 2)
					dt = $urandom;
				else
					dt = $urandom_range(12);
				send_item(MODE_TICK, dt, $urandom, 1'($urandom_range(1)),
					IDX_W'($urandom_range(15)));
			end else if (pick < 70) begin
				dur = (sel == 0) ? $urandom : $urandom_range(40);
				send_item(MODE_SET, $urandom, dur, 1'($urandom_range(1)),
					IDX_W'($urandom_range(15)));
			end else if (pick < 78) begin
				send_item(MODE_PAUSE, $urandom, $urandom, 1'($urandom_range(1)), sl);
			end else begin
				send_item(MODE_CANCEL, $urandom, $urandom, 1'($urandom_range(1)), sl);
			end
		end
	endtask

	initial begin
		int s;
		for (s = 0; s < SLOTS; s++) begin
			time_left[s] = '0;
			time_len[s]  = '0;
			live[s]      = 1'b0;
			paused[s]    = 1'b0;
			looping[s]   = 1'b0;
		end
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_idle_bank();
		test_timer_cases();
		test_bank_full();
		test_random(38, 0, 0);
		test_random(38, 85, 0);
		test_random(38, 0, 85);
		test_random(38, 34, 34);
		in_valid <= 1'b0;

		// drain outstanding results, then give the block time to go quiet
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
